/* hdl/wurm_pkg.sv */
// package: sizes, codes and transaction types of the wildcard url route matcher
`default_nettype none

package wurm_pkg;

    localparam int NUM_PATTERNS    = 16;
    localparam int MAX_PATTERN_LEN = 64;

    localparam int SLOT_W = 4;
    localparam int CPOS_W = 6;
    localparam int CHAR_W = 8;
    localparam int LEN_W  = 7;
    localparam int SITE_W = 16;
    localparam int MODE_W = 2;
    localparam int CFG_W  = 5;

    localparam int ADDR_W = $clog2(MAX_PATTERN_LEN);
    localparam int UPOS_W = $clog2(MAX_PATTERN_LEN + 1);
    localparam int CNT_W  = $clog2(NUM_PATTERNS + 1);

    localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;

    localparam logic [MODE_W-1:0] MODE_CHAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_META = 2'd1;
    localparam logic [MODE_W-1:0] MODE_URL  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot;
        logic [CPOS_W-1:0] char_pos;
        logic [CHAR_W-1:0] char_value;
        logic [LEN_W-1:0]  pattern_length;
        logic [SITE_W-1:0] entry_site;
        logic              url_last;
    } t_in_item;

    typedef struct packed {
        logic              matched;
        logic              exact;
        logic [SITE_W-1:0] site_id;
    } t_out_item;

    // token walking down the cell chain, one cell per cycle
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [CHAR_W-1:0] ch;
        logic [UPOS_W-1:0] pos;
        logic              exact_found;
        logic [SITE_W-1:0] exact_site;
        logic              star_found;
        logic [SITE_W-1:0] star_site;
    } t_tok;

    // table write for one cell
    typedef struct packed {
        logic              char_we;
        logic              meta_we;
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  len;
        logic [SITE_W-1:0] site;
    } t_cell_wr;

endpackage

`default_nettype wire

/* hdl/wurm_cell.sv */
// one pattern slot: character memory, length, site, alive bit and a token stage
`default_nettype none

module wurm_cell
    import wurm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CNT_W-1:0] i_idx,
    input  wire logic [CNT_W-1:0] i_count,
    input  wire t_cell_wr         i_wr,
    input  wire logic             i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    input  wire t_tok             i_tok,
    output t_tok                  o_tok
);

    logic [CHAR_W-1:0] r_mem [MAX_PATTERN_LEN];
    logic [CHAR_W-1:0] r_rd;
    logic [LEN_W-1:0]  r_len;
    logic [SITE_W-1:0] r_site;
    logic              r_alive;
    t_tok              r_tok;

    logic alive_ok;
    logic char_ok;
    logic hit;
    logic ends_here;
    logic n_alive;
    t_tok n_tok;

    // pattern characters, read data registered
    always_ff @(posedge i_clk) begin
        if (i_wr.char_we) begin
            r_mem[i_wr.addr] <= i_wr.ch;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    always_comb begin
        alive_ok  = r_alive && (i_idx < i_count) && (r_len != '0)
                    && (r_len <= LEN_W'(MAX_PATTERN_LEN)) && (i_tok.pos < r_len);
        char_ok   = (r_rd == i_tok.ch) || (r_rd == STAR_CHAR);
        hit       = alive_ok && char_ok;
        ends_here = hit && ((i_tok.pos + UPOS_W'(1)) == r_len);

        n_tok = i_tok;
        if (ends_here) begin
            if (i_tok.last) begin
                if (!i_tok.exact_found) begin
                    n_tok.exact_found = 1'b1;
                    n_tok.exact_site  = r_site;
                end
            end else if (r_rd == STAR_CHAR) begin
                n_tok.star_found = 1'b1;
                n_tok.star_site  = r_site;
            end
        end

        n_alive = r_alive;
        if (i_tok.valid) begin
            n_alive = i_tok.last ? 1'b1 : hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_site      <= '0;
            r_alive     <= 1'b1;
            r_tok.valid <= 1'b0;
        end else begin
            if (i_wr.meta_we) begin
                r_len  <= i_wr.len;
                r_site <= i_wr.site;
            end
            r_alive <= n_alive;
            r_tok   <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

/* hdl/wildcard_url_route_matcher.sv */
// top level: wildcard url route matcher built from a chain of pattern cells
//
// input channel (i_in_valid / o_in_ready, payload t_in_item) takes three kinds
// of transaction: mode 0 writes one pattern character, mode 1 writes a slot's
// length and site number, mode 2 streams one url character. mode 3 is dropped.
// table writes complete in the accept cycle. a url character is looked up in
// every cell's character memory at once, then a token carrying the character
// and the best match so far walks the chain, one cell per cycle, lowest slot
// first. the block takes no new transaction until that token leaves the chain,
// nor on the last character until the result has moved to the output register.
// on the last url character the result goes to that output register
// (o_out_valid / i_out_ready, payload t_out_item) once the token has left the
// chain and the register is free. a stalled receiver holds only that register:
// the block keeps taking table writes and url characters until a second result
// must be stored. i_cfg_we writes pattern_count (clamped to NUM_PATTERNS) with
// no wait; the user must write it only while idle, the block does not enforce it.
// synchronous active-low reset clears lengths, sites, the count and the url
// state; pattern characters are undefined until written.
`default_nettype none

module wildcard_url_route_matcher
    import wurm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_item         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_item             o_out_data,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FLUSH
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [UPOS_W-1:0] r_url_pos;
    logic              r_star_found;
    logic [SITE_W-1:0] r_star_site;
    t_tok              r_tok;
    t_out_item         r_pend;
    logic              r_out_valid;
    t_out_item         r_out;

    logic in_acc;
    logic url_acc;
    t_tok w_tok [NUM_PATTERNS+1];
    logic [NUM_PATTERNS:0] w_tok_valid;
    t_tok chain_end;
    t_out_item n_result;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign url_acc    = in_acc && (i_in_data.mode == MODE_URL);

    assign w_tok[0] = r_tok;
    assign chain_end = w_tok[NUM_PATTERNS];

    // the chain: each cell owns one slot and passes the token on
    for (genvar j = 0; j < NUM_PATTERNS; j++) begin : g_cell
        t_cell_wr w_wr;

        always_comb begin
            w_wr.char_we = in_acc && (i_in_data.mode == MODE_CHAR)
                           && (int'(i_in_data.slot) == j)
                           && (int'(i_in_data.char_pos) < MAX_PATTERN_LEN);
            w_wr.meta_we = in_acc && (i_in_data.mode == MODE_META)
                           && (int'(i_in_data.slot) == j);
            w_wr.addr    = ADDR_W'(i_in_data.char_pos);
            w_wr.ch      = i_in_data.char_value;
            w_wr.len     = i_in_data.pattern_length;
            w_wr.site    = i_in_data.entry_site;
        end

        wurm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_idx     (CNT_W'(j)),
            .i_count   (r_count),
            .i_wr      (w_wr),
            .i_rd_en   (url_acc),
            .i_rd_addr (r_url_pos[ADDR_W-1:0]),
            .i_tok     (w_tok[j]),
            .o_tok     (w_tok[j+1])
        );
    end

    for (genvar k = 0; k <= NUM_PATTERNS; k++) begin : g_vld
        assign w_tok_valid[k] = w_tok[k].valid;
    end

    // exact match beats a trailing-star prefix match
    always_comb begin
        n_result = '0;
        if (chain_end.exact_found) begin
            n_result.matched = 1'b1;
            n_result.exact   = 1'b1;
            n_result.site_id = chain_end.exact_site;
        end else if (chain_end.star_found) begin
            n_result.matched = 1'b1;
            n_result.site_id = chain_end.star_site;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_url_pos    <= '0;
            r_star_found <= 1'b0;
            r_star_site  <= '0;
            r_tok.valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= (int'(i_cfg_data) > NUM_PATTERNS) ? CNT_W'(NUM_PATTERNS)
                                                              : CNT_W'(i_cfg_data);
            end

            // token injection: char, position and star state so far
            r_tok.valid <= url_acc;
            if (url_acc) begin
                r_tok.last        <= i_in_data.url_last;
                r_tok.ch          <= i_in_data.char_value;
                r_tok.pos         <= r_url_pos;
                r_tok.exact_found <= 1'b0;
                r_tok.exact_site  <= '0;
                r_tok.star_found  <= r_star_found;
                r_tok.star_site   <= r_star_site;
            end

            // the flush step reloads the output register itself
            if (r_out_valid && i_out_ready && (r_state != S_FLUSH)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (url_acc) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (chain_end.valid) begin
                        if (chain_end.last) begin
                            // url done: reset url state, hold result
                            r_url_pos    <= '0;
                            r_star_found <= 1'b0;
                            r_star_site  <= '0;
                            r_pend       <= n_result;
                            r_state      <= S_FLUSH;
                        end else begin
                            r_star_found <= chain_end.star_found;
                            r_star_site  <= chain_end.star_site;
                            if (r_url_pos < UPOS_W'(MAX_PATTERN_LEN)) begin
                                r_url_pos <= r_url_pos + UPOS_W'(1);
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_FLUSH: begin
                    // wait for the output register to free up
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out       <= r_pend;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // only one url character in flight along the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_valid))
        else $error("more than one token in the cell chain");

    // idle means the chain is empty
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_tok_valid == '0))
        else $error("token in chain while idle");

    // a new result only comes out of the flush step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FLUSH))
        else $error("result appeared without a finished url");

    // url position saturates at the longest pattern
    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_url_pos <= UPOS_W'(MAX_PATTERN_LEN))
        else $error("url position past saturation");

    // a no-match result carries site zero
    a_nomatch_site: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.matched) |-> (r_out.site_id == '0 && !r_out.exact))
        else $error("no-match result with nonzero site or exact flag");

endmodule

`default_nettype wire

/* test/wildcard_url_route_matcher_tb.sv */
// testbench for the wildcard url route matcher: directed table then random traffic
`timescale 1ns / 1ps

module wildcard_url_route_matcher_tb;
    import wurm_pkg::*;

    // mode 3 has no meaning, the block drops it
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int DIRECTED_ROWS  = 25;
    localparam int PHASES         = 8;
    localparam int PHASE_TXNS     = 140;
    // a url character walks the whole cell chain before the block is quiet
    localparam int SETTLE_CYCLES  = 3 * (NUM_PATTERNS + 2);
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RESET_CYCLES   = 7;

    localparam t_out_item NO_ROUTE = '0;

    // one row of the directed table; preset marks a result typed in by hand
    typedef struct packed {
        t_in_item  txn;
        logic      preset;
        t_out_item want;
    } t_route_case;

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    t_in_item         i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_item        o_out_data;
    logic             i_cfg_we    = 1'b0;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    wildcard_url_route_matcher u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // route table and url walk as the testbench believes them to be
    // ------------------------------------------------------------------
    logic [CHAR_W-1:0]       route_chars [NUM_PATTERNS][MAX_PATTERN_LEN];
    logic [LEN_W-1:0]        route_len   [NUM_PATTERNS];
    logic [SITE_W-1:0]       route_site  [NUM_PATTERNS];
    int unsigned             route_count;
    int unsigned             url_pos;
    logic [NUM_PATTERNS-1:0] alive;
    logic                    star_hit;
    logic [SITE_W-1:0]       star_hit_site;

    // which pattern characters have been written, so no length ever exposes
    // a character that was never loaded
    logic [MAX_PATTERN_LEN-1:0] chars_loaded [NUM_PATTERNS];

    t_out_item pending_routes [$];
    int        mismatches   = 0;
    int        txns_sent    = 0;
    int        quiet_cycles = 0;
    // steady turns off idling on both sides, rx_hold_req asks for a long stall
    bit        steady       = 1'b0;
    bit        rx_hold_req  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic clear_url_walk();
        url_pos       = 0;
        alive         = '1;
        star_hit      = 1'b0;
        star_hit_site = '0;
    endtask

    // one accepted transaction through the route table; a result only comes
    // out on the last url character
    task automatic route_step(input t_in_item t, output bit has_route,
                              output t_out_item route);
        int unsigned       plen;
        logic [CHAR_W-1:0] pc;
        bit                exact_hit;
        logic [SITE_W-1:0] exact_site;
        has_route  = 1'b0;
        route      = NO_ROUTE;
        exact_hit  = 1'b0;
        exact_site = '0;
        case (t.mode)
            MODE_CHAR: route_chars[t.slot][t.char_pos] = t.char_value;
            MODE_META: begin
                route_len[t.slot]  = t.pattern_length;
                route_site[t.slot] = t.entry_site;
            end
            MODE_URL: begin
                // lowest slot first: first exact hit sticks, later star hits overwrite
                for (int j = 0; j < NUM_PATTERNS; j++) begin
                    plen = route_len[j];
                    if (alive[j]) begin
                        if (j >= route_count || plen == 0 || plen > MAX_PATTERN_LEN ||
                            url_pos >= plen) begin
                            alive[j] = 1'b0;
                        end else begin
                            pc = route_chars[j][url_pos];
                            if (pc != t.char_value && pc != STAR_CHAR) begin
                                alive[j] = 1'b0;
                            end else if (url_pos + 1 == plen) begin
                                if (t.url_last) begin
                                    if (!exact_hit) begin
                                        exact_hit  = 1'b1;
                                        exact_site = route_site[j];
                                    end
                                end else if (pc == STAR_CHAR) begin
                                    star_hit      = 1'b1;
                                    star_hit_site = route_site[j];
                                end
                            end
                        end
                    end
                end
                // position saturates on very long urls
                if (url_pos < MAX_PATTERN_LEN) url_pos++;
                if (t.url_last) begin
                    has_route = 1'b1;
                    if (exact_hit) route = {1'b1, 1'b1, exact_site};
                    else if (star_hit) route = {1'b1, 1'b0, star_hit_site};
                    clear_url_walk();
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // transaction builders; fields a mode does not use carry random bits
    // ------------------------------------------------------------------
    function automatic t_in_item noise_txn(input logic [MODE_W-1:0] mode);
        logic [63:0] raw;
        t_in_item    t;
        raw    = {$urandom, $urandom};
        t      = raw[$bits(t_in_item)-1:0];
        t.mode = mode;
        return t;
    endfunction

    function automatic t_in_item char_txn(input int unsigned slot, input int unsigned pos,
                                          input logic [CHAR_W-1:0] ch);
        t_in_item t;
        t            = noise_txn(MODE_CHAR);
        t.slot       = SLOT_W'(slot);
        t.char_pos   = CPOS_W'(pos);
        t.char_value = ch;
        return t;
    endfunction

    function automatic t_in_item meta_txn(input int unsigned slot, input int unsigned len,
                                          input int unsigned site);
        t_in_item t;
        t                = noise_txn(MODE_META);
        t.slot           = SLOT_W'(slot);
        t.pattern_length = LEN_W'(len);
        t.entry_site     = SITE_W'(site);
        return t;
    endfunction

    function automatic t_in_item url_txn(input logic [CHAR_W-1:0] ch, input logic last);
        t_in_item t;
        t            = noise_txn(MODE_URL);
        t.char_value = ch;
        t.url_last   = last;
        return t;
    endfunction

    // mostly a tiny alphabet so urls hit patterns, now and then any byte
    function automatic logic [CHAR_W-1:0] pick_char(input bit allow_star);
        int unsigned r;
        r = $urandom_range(99);
        if (allow_star && r < 20) return STAR_CHAR;
        if (r < 80) begin
            case ($urandom_range(3))
                0:       return "a";
                1:       return "b";
                2:       return "/";
                default: return ".";
            endcase
        end
        return CHAR_W'($urandom_range(255));
    endfunction

    // ------------------------------------------------------------------
    // input side: random idle, hold valid until accepted, then predict
    // ------------------------------------------------------------------
    task automatic send_txn(input t_in_item t, input logic preset, input t_out_item want);
        bit        has_route;
        t_out_item route;
        while (!steady && $urandom_range(99) < 16) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= t;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        route_step(t, has_route, route);
        if (has_route) pending_routes = {pending_routes, (preset ? want : route)};
        if (t.mode == MODE_CHAR) chars_loaded[t.slot][t.char_pos] = 1'b1;
        if (t.mode != MODE_UNUSED) txns_sent++;
    endtask

    // register write only with the block quiet: results drained, and long
    // enough for a url character that gives no result to leave the chain
    task automatic set_route_count(input logic [CFG_W-1:0] v);
        i_in_valid <= 1'b0;
        while (pending_routes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        route_count = (v > NUM_PATTERNS) ? NUM_PATTERNS : v;
    endtask

    // ------------------------------------------------------------------
    // random traffic pieces
    // ------------------------------------------------------------------
    task automatic scribble();
        send_txn(char_txn($urandom_range(NUM_PATTERNS - 1), $urandom_range(MAX_PATTERN_LEN - 1),
                          pick_char(1'b1)), 1'b0, NO_ROUTE);
    endtask

    // new pattern in a slot: characters first, length and site last
    task automatic load_pattern();
        int unsigned slot;
        int unsigned len;
        int unsigned r;
        if (route_count > 0 && $urandom_range(99) < 80) slot = $urandom_range(route_count - 1);
        else slot = $urandom_range(NUM_PATTERNS - 1);
        r = $urandom_range(99);
        if (r < 4) len = 0;
        else if (r < 8) len = $urandom_range(127, MAX_PATTERN_LEN + 1);
        else if (r < 10) len = MAX_PATTERN_LEN;
        else len = $urandom_range(1, 10);
        // over-long patterns never match, so their characters are not needed
        if (len <= MAX_PATTERN_LEN) begin
            for (int p = 0; p < len; p++) begin
                if (!chars_loaded[slot][p] || len <= 16)
                    send_txn(char_txn(slot, p, pick_char(1'b1)), 1'b0, NO_ROUTE);
            end
        end
        send_txn(meta_txn(slot, len, $urandom_range(16'hFFFF)), 1'b0, NO_ROUTE);
    endtask

    // new length on a slot: zero, over-long, or never past its loaded prefix
    task automatic retune_slot();
        int unsigned slot;
        int unsigned loaded;
        int unsigned len;
        slot   = $urandom_range(NUM_PATTERNS - 1);
        loaded = 0;
        while (loaded < MAX_PATTERN_LEN && chars_loaded[slot][loaded]) loaded++;
        case ($urandom_range(2))
            0:       len = 0;
            1:       len = $urandom_range(127, MAX_PATTERN_LEN + 1);
            default: len = $urandom_range(loaded);
        endcase
        send_txn(meta_txn(slot, len, $urandom_range(16'hFFFF)), 1'b0, NO_ROUTE);
    endtask

    // url shaped on one pattern in use: exact length, longer (star prefix),
    // shorter, saturating, or plain random; stars get filled with random characters
    task automatic stream_url();
        int unsigned       target;
        int unsigned       plen;
        int unsigned       ulen;
        int unsigned       r;
        logic [CHAR_W-1:0] ch;
        if (route_count > 0) target = $urandom_range(route_count - 1);
        else target = $urandom_range(NUM_PATTERNS - 1);
        plen = route_len[target];
        if (plen > MAX_PATTERN_LEN) plen = 0;
        r = $urandom_range(99);
        if (r < 12 || plen == 0) ulen = $urandom_range(1, 6);
        else if (r < 16) ulen = $urandom_range(MAX_PATTERN_LEN + 1, MAX_PATTERN_LEN + 6);
        else if (r < 60) ulen = plen;
        else if (r < 85) ulen = plen + $urandom_range(1, 4);
        else ulen = (plen > 1) ? plen - 1 : plen + 1;
        for (int i = 0; i < ulen; i++) begin
            if (i < plen && $urandom_range(99) >= 5) begin
                ch = route_chars[target][i];
                if (ch == STAR_CHAR) ch = pick_char(1'b0);
            end else begin
                ch = pick_char(1'b0);
            end
            // table writes may land in the middle of a url
            if ($urandom_range(99) < 3) scribble();
            send_txn(url_txn(ch, i == ulen - 1), 1'b0, NO_ROUTE);
        end
    endtask

    // ------------------------------------------------------------------
    // output side: check each result, random stalls, one long hold-off
    // ------------------------------------------------------------------
    task automatic check_route(input t_out_item got);
        t_out_item want;
        if (pending_routes.size() == 0) begin
            $display("%0t: result with none expected, got matched=%0b exact=%0b site=%h",
                     $time, got.matched, got.exact, got.site_id);
            mismatches++;
        end else begin
            want = pending_routes.pop_front();
            if (got.matched !== want.matched || got.exact !== want.exact ||
                got.site_id !== want.site_id) begin
                $display("%0t: expected matched=%0b exact=%0b site=%h, got matched=%0b exact=%0b site=%h",
                         $time, want.matched, want.exact, want.site_id,
                         got.matched, got.exact, got.site_id);
                mismatches++;
            end
        end
    endtask

    initial begin
        int unsigned hold_left;
        hold_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) check_route(o_out_data);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= steady || ($urandom_range(99) >= 16);
            end
        end
    end

    // ends the run when no transaction moves on either channel for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        t_route_case      route_cases [DIRECTED_ROWS];
        logic [CFG_W-1:0] plan_count;
        int unsigned      goal;
        int unsigned      r;

        for (int s = 0; s < NUM_PATTERNS; s++) begin
            route_len[s]    = '0;
            route_site[s]   = '0;
            chars_loaded[s] = '0;
        end
        route_count = 0;
        clear_url_walk();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // count above the slot total clamps to all slots
        set_route_count(5'd31);

        // nothing loaded after reset: no match
        route_cases[0]  = {url_txn("a", 1'b1), 1'b1, NO_ROUTE};
        // slot 0 "a*", slot 1 "a", slot 15 a zero byte, slots 13 and 14 "*"
        route_cases[1]  = {char_txn(0, 0, "a"), 1'b0, NO_ROUTE};
        route_cases[2]  = {char_txn(0, 1, STAR_CHAR), 1'b0, NO_ROUTE};
        route_cases[3]  = {meta_txn(0, 2, 16'hFFFF), 1'b0, NO_ROUTE};
        route_cases[4]  = {char_txn(1, 0, "a"), 1'b0, NO_ROUTE};
        route_cases[5]  = {meta_txn(1, 1, 16'h0001), 1'b0, NO_ROUTE};
        route_cases[6]  = {char_txn(15, 0, 8'h00), 1'b0, NO_ROUTE};
        route_cases[7]  = {meta_txn(15, 1, 16'h8000), 1'b0, NO_ROUTE};
        route_cases[8]  = {char_txn(14, 0, STAR_CHAR), 1'b0, NO_ROUTE};
        route_cases[9]  = {meta_txn(14, 1, 16'h00EE), 1'b0, NO_ROUTE};
        route_cases[10] = {char_txn(13, 0, STAR_CHAR), 1'b0, NO_ROUTE};
        route_cases[11] = {meta_txn(13, 1, 16'h0D0D), 1'b0, NO_ROUTE};
        // several exact hits: the lowest slot wins
        route_cases[12] = {url_txn("a", 1'b1), 1'b1, t_out_item'({1'b1, 1'b1, 16'h0001})};
        // star as the final character of an exact match
        route_cases[13] = {url_txn("a", 1'b0), 1'b0, NO_ROUTE};
        route_cases[14] = {url_txn("z", 1'b1), 1'b0, NO_ROUTE};
        // later star prefix beats an earlier one
        route_cases[15] = {url_txn("a", 1'b0), 1'b0, NO_ROUTE};
        route_cases[16] = {url_txn("q", 1'b0), 1'b0, NO_ROUTE};
        route_cases[17] = {url_txn("r", 1'b1), 1'b0, NO_ROUTE};
        // two star prefixes ending together: the highest slot wins
        route_cases[18] = {url_txn("x", 1'b0), 1'b0, NO_ROUTE};
        route_cases[19] = {url_txn("y", 1'b1), 1'b0, NO_ROUTE};
        // zero byte is an ordinary character
        route_cases[20] = {url_txn(8'h00, 1'b1), 1'b0, NO_ROUTE};
        // top character position, over-long pattern, dropped mode
        route_cases[21] = {char_txn(2, MAX_PATTERN_LEN - 1, 8'hFF), 1'b0, NO_ROUTE};
        route_cases[22] = {meta_txn(2, 127, 16'h1234), 1'b0, NO_ROUTE};
        route_cases[23] = {noise_txn(MODE_UNUSED), 1'b0, NO_ROUTE};
        route_cases[24] = {url_txn(8'hFF, 1'b1), 1'b0, NO_ROUTE};

        for (int k = 0; k < DIRECTED_ROWS; k++)
            send_txn(route_cases[k].txn, route_cases[k].preset, route_cases[k].want);

        // random phases, each under its own slot count
        for (int k = 0; k < PHASES; k++) begin
            case (k)
                0:       plan_count = 5'd16;
                1:       plan_count = 5'd0;
                2:       plan_count = 5'd31;
                3:       plan_count = 5'd1;
                4:       plan_count = CFG_W'($urandom_range(31));
                5:       plan_count = 5'd17;
                6:       plan_count = 5'd8;
                default: plan_count = 5'd16;
            endcase
            set_route_count(plan_count);
            // receiver stalls long while urls keep coming, so the block backs up
            if (k == 0) rx_hold_req = 1'b1;
            steady = (k == 2);
            goal   = txns_sent + PHASE_TXNS;
            while (txns_sent < goal) begin
                r = $urandom_range(99);
                if (r < 20) load_pattern();
                else if (r < 24) retune_slot();
                else if (r < 27) scribble();
                else if (r < 30) send_txn(noise_txn(MODE_UNUSED), 1'b0, NO_ROUTE);
                else stream_url();
            end
            steady = 1'b0;
        end

        // drain and let the chain go quiet
        i_in_valid <= 1'b0;
        while (pending_routes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_routes.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* filelist.f */
hdl/wurm_pkg.sv
hdl/wurm_cell.sv
hdl/wildcard_url_route_matcher.sv
test/wildcard_url_route_matcher_tb.sv
